// ===== hdl/sndc_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the strided copy core.
package sndc_pkg;

   localparam int MAX_DIMS_DEF  = 7;
   localparam int ADDR_BITS_DEF = 48;

   localparam int OUT_ADDR_W = 48;
   localparam int COUNT_W    = 28;
   localparam int LEN_W      = 16;
   localparam int STR_W      = 16;
   localparam int DIST_W     = 24;
   localparam int BSTR_W     = 40;
   localparam int EB_W       = 13;
   localparam int PROD_W     = EB_W + LEN_W;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // operation codes
   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_RESTART = 2'd1;
   localparam logic [1:0] OP_STEP    = 2'd2;
   localparam logic [1:0] OP_UNUSED  = 2'd3;

   // copy_mode codes
   localparam logic [1:0] MODE_PACK      = 2'd0;
   localparam logic [1:0] MODE_UNPACK    = 2'd1;
   localparam logic [1:0] MODE_SCALAR    = 2'd2;
   localparam logic [1:0] MODE_UNDEFINED = 2'd3;

   // copy_mode bits
   localparam int MODE_UNPACK_BIT = 0;
   localparam int MODE_SCALAR_BIT = 1;

   // register indexes (paddr[5:3])
   localparam logic [2:0] CSR_COPY_MODE     = 3'd0;
   localparam logic [2:0] CSR_ELEMENT_BYTES = 3'd1;
   localparam logic [2:0] CSR_DIM_COUNT     = 3'd2;
   localparam logic [2:0] CSR_DEST_BASE     = 3'd3;
   localparam logic [2:0] CSR_SRC_BASE      = 3'd4;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_LOAD  = 6'b000010,
      ST_CLEAR = 6'b000100,
      ST_SCAN  = 6'b001000,
      ST_ADV   = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   typedef struct packed {
      logic capture;
      logic load_wr;
      logic clear;
      logic scan_step;
      logic adv_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic scan_end;
      logic adv_end;
      logic out_free;
   } status_type;

endpackage

// ===== hdl/sndc_ctrl.sv =====
// Sequencing state machine for the strided copy core.
module sndc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_operation,
   output logic                  req_stall,
   input  sndc_pkg::status_type  status,
   output sndc_pkg::cmd_type     cmd
);
   import sndc_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_operation)
                  OP_LOAD:    state_in = ST_LOAD;
                  OP_RESTART: state_in = ST_CLEAR;
                  OP_STEP:    state_in = ST_SCAN;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD: begin
            cmd.load_wr = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_end) begin
               state_in = ST_ADV;
            end
         end
         ST_ADV: begin
            cmd.adv_step = 1'b1;
            if (status.adv_end) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/sndc_dp.sv =====
// Descriptor tables, index counters, offset scan and result register.
module sndc_dp #(
   parameter int MAX_DIMS  = sndc_pkg::MAX_DIMS_DEF,
   parameter int ADDR_BITS = sndc_pkg::ADDR_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sndc_pkg::cmd_type                 cmd,
   output sndc_pkg::status_type              status,
   input  logic [2:0]                        req_dim_index,
   input  logic [sndc_pkg::LEN_W-1:0]        req_dim_length,
   input  logic [sndc_pkg::STR_W-1:0]        req_dim_stride,
   input  logic [sndc_pkg::DIST_W-1:0]       req_dim_distance,
   input  logic [1:0]                        copy_mode,
   input  logic [sndc_pkg::EB_W-1:0]         element_bytes,
   input  logic [2:0]                        dim_count,
   input  logic [sndc_pkg::OUT_ADDR_W-1:0]   dest_base,
   input  logic [sndc_pkg::OUT_ADDR_W-1:0]   src_base,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [sndc_pkg::OUT_ADDR_W-1:0]   rsp_dest_address,
   output logic [sndc_pkg::OUT_ADDR_W-1:0]   rsp_source_address,
   output logic [sndc_pkg::COUNT_W-1:0]      rsp_byte_count,
   output logic                              rsp_skip,
   output logic                              rsp_last,
   output logic                              rsp_done_res
);
   import sndc_pkg::*;

   localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int AW = ADDR_BITS;
   localparam logic [3:0]    MaxDimsW = 4'(MAX_DIMS);
   localparam logic [DW-1:0] LastDimMax = DW'(MAX_DIMS - 1);

   // captured load fields
   logic [2:0]        didx_ff, didx_in;
   logic [LEN_W-1:0]  dlen_ff, dlen_in;
   logic [STR_W-1:0]  dstr_ff, dstr_in;
   logic [DIST_W-1:0] ddist_ff, ddist_in;

   // descriptor tables and progress
   logic [LEN_W-1:0]  len_tab_ff  [MAX_DIMS];
   logic [LEN_W-1:0]  len_tab_in  [MAX_DIMS];
   logic [BSTR_W-1:0] bstr_tab_ff [MAX_DIMS];
   logic [BSTR_W-1:0] bstr_tab_in [MAX_DIMS];
   logic              unit_tab_ff [MAX_DIMS];
   logic              unit_tab_in [MAX_DIMS];
   logic [LEN_W-1:0]  idx_ff      [MAX_DIMS];
   logic [LEN_W-1:0]  idx_in      [MAX_DIMS];
   logic [AW-1:0]     doff_ff     [MAX_DIMS];
   logic [AW-1:0]     doff_in     [MAX_DIMS];
   logic [AW-1:0]     packed_ff, packed_in;
   logic              finished_ff, finished_in;

   // per-step working registers
   logic [DW-1:0]     dim_ff, dim_in;
   logic [AW-1:0]     offset_ff, offset_in;
   logic              empty_ff, empty_in;
   logic              merged_ff, merged_in;
   logic              noloops_ff, noloops_in;
   logic              done_ff, done_in;
   logic              last_ff, last_in;
   logic [PROD_W-1:0] prod_ff, prod_in;

   // result register
   logic                  rvalid_ff, rvalid_in;
   logic [OUT_ADDR_W-1:0] rdest_ff, rdest_in;
   logic [OUT_ADDR_W-1:0] rsrc_ff, rsrc_in;
   logic [COUNT_W-1:0]    rcount_ff, rcount_in;
   logic                  rskip_ff, rskip_in;
   logic                  rlast_ff, rlast_in;
   logic                  rdone_ff, rdone_in;

   logic [DW-1:0]     n_m1;
   logic              scalar;
   logic              merged_now;
   logic              at_end;
   logic              wrap;
   logic              adv_active;
   logic [BSTR_W-1:0] load_prod;
   logic [AW-1:0]     dest_aw, src_aw, stride_aw, chunk_aw;
   logic [AW-1:0]     dst_aw, srcsel_aw;
   logic [COUNT_W-1:0] chunk;

   assign scalar     = copy_mode[MODE_SCALAR_BIT];
   assign merged_now = !scalar && unit_tab_ff[dim_ff];
   assign at_end     = (dim_ff == n_m1);
   assign load_prod  = BSTR_W'(dstr_ff) * BSTR_W'(ddist_ff);
   assign dest_aw    = AW'(64'(dest_base));
   assign src_aw     = AW'(64'(src_base));
   assign stride_aw  = AW'(64'(bstr_tab_ff[dim_ff]));
   assign wrap = ({1'b0, idx_ff[dim_ff]} + 17'd1) >= {1'b0, len_tab_ff[dim_ff]};
   assign adv_active = cmd.adv_step && !done_ff && !noloops_ff;
   assign chunk = merged_ff ? (prod_ff[PROD_W-1] ? COUNT_MAX : prod_ff[COUNT_W-1:0])
                            : COUNT_W'(element_bytes);
   assign chunk_aw = AW'(chunk);

   always_comb begin
      if (dim_count == 3'd0) begin
         n_m1 = '0;
      end else if ({1'b0, dim_count} > MaxDimsW) begin
         n_m1 = LastDimMax;
      end else begin
         n_m1 = DW'(dim_count - 3'd1);
      end
   end

   always_comb begin
      if (scalar) begin
         dst_aw    = dest_aw + offset_ff;
         srcsel_aw = src_aw;
      end else if (!copy_mode[MODE_UNPACK_BIT]) begin
         dst_aw    = dest_aw + packed_ff;
         srcsel_aw = src_aw + offset_ff;
      end else begin
         dst_aw    = dest_aw + offset_ff;
         srcsel_aw = src_aw + packed_ff;
      end
   end

   always_comb begin
      didx_in     = didx_ff;
      dlen_in     = dlen_ff;
      dstr_in     = dstr_ff;
      ddist_in    = ddist_ff;
      len_tab_in  = len_tab_ff;
      bstr_tab_in = bstr_tab_ff;
      unit_tab_in = unit_tab_ff;
      idx_in      = idx_ff;
      doff_in     = doff_ff;
      packed_in   = packed_ff;
      finished_in = finished_ff;
      dim_in      = dim_ff;
      offset_in   = offset_ff;
      empty_in    = empty_ff;
      merged_in   = merged_ff;
      noloops_in  = noloops_ff;
      done_in     = done_ff;
      last_in     = last_ff;
      prod_in     = prod_ff;
      rvalid_in   = rvalid_ff && rsp_stall;
      rdest_in    = rdest_ff;
      rsrc_in     = rsrc_ff;
      rcount_in   = rcount_ff;
      rskip_in    = rskip_ff;
      rlast_in    = rlast_ff;
      rdone_in    = rdone_ff;

      if (cmd.capture) begin
         didx_in   = req_dim_index;
         dlen_in   = req_dim_length;
         dstr_in   = req_dim_stride;
         ddist_in  = req_dim_distance;
         dim_in    = '0;
         offset_in = '0;
         empty_in  = 1'b0;
         last_in   = 1'b1;
      end

      if (cmd.load_wr && ({1'b0, didx_ff} < MaxDimsW)) begin
         len_tab_in[DW'(didx_ff)]  = dlen_ff;
         bstr_tab_in[DW'(didx_ff)] = load_prod;
         unit_tab_in[DW'(didx_ff)] = (dstr_ff == 16'd1);
      end

      if (cmd.clear) begin
         for (int i = 0; i < MAX_DIMS; i++) begin
            idx_in[i]  = '0;
            doff_in[i] = '0;
         end
         packed_in   = '0;
         finished_in = 1'b0;
      end

      if (cmd.scan_step) begin
         empty_in = empty_ff || (len_tab_ff[dim_ff] == '0);
         if (!at_end || !merged_now) begin
            offset_in = offset_ff + doff_ff[dim_ff];
         end
         if (at_end) begin
            merged_in  = merged_now;
            noloops_in = merged_now && (n_m1 == '0);
            dim_in     = merged_now ? DW'(n_m1 - 1'b1) : n_m1;
            prod_in    = PROD_W'(element_bytes) * PROD_W'(len_tab_ff[dim_ff]);
            done_in    = finished_ff || empty_in;
         end else begin
            dim_in = DW'(dim_ff + 1'b1);
         end
      end

      if (adv_active) begin
         if (wrap) begin
            idx_in[dim_ff]  = '0;
            doff_in[dim_ff] = '0;
            if (dim_ff != '0) begin
               dim_in = DW'(dim_ff - 1'b1);
            end
         end else begin
            idx_in[dim_ff]  = idx_ff[dim_ff] + 16'd1;
            doff_in[dim_ff] = doff_ff[dim_ff] + stride_aw;
            last_in         = 1'b0;
         end
      end

      if (cmd.emit) begin
         rvalid_in = 1'b1;
         if (done_ff) begin
            rdest_in  = '0;
            rsrc_in   = '0;
            rcount_in = '0;
            rskip_in  = 1'b0;
            rlast_in  = 1'b0;
            rdone_in  = 1'b1;
         end else begin
            rdest_in  = OUT_ADDR_W'(64'(dst_aw));
            rsrc_in   = OUT_ADDR_W'(64'(srcsel_aw));
            rcount_in = chunk;
            rskip_in  = scalar && (dst_aw == srcsel_aw);
            rlast_in  = last_ff;
            rdone_in  = 1'b0;
            if (!scalar) begin
               packed_in = packed_ff + chunk_aw;
            end
            if (last_ff) begin
               finished_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_DIMS; i++) begin
            len_tab_ff[i]  <= '0;
            bstr_tab_ff[i] <= '0;
            unit_tab_ff[i] <= 1'b0;
            idx_ff[i]      <= '0;
            doff_ff[i]     <= '0;
         end
         packed_ff   <= '0;
         finished_ff <= 1'b0;
         rvalid_ff   <= 1'b0;
      end else begin
         len_tab_ff  <= len_tab_in;
         bstr_tab_ff <= bstr_tab_in;
         unit_tab_ff <= unit_tab_in;
         idx_ff      <= idx_in;
         doff_ff     <= doff_in;
         packed_ff   <= packed_in;
         finished_ff <= finished_in;
         rvalid_ff   <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      didx_ff    <= didx_in;
      dlen_ff    <= dlen_in;
      dstr_ff    <= dstr_in;
      ddist_ff   <= ddist_in;
      dim_ff     <= dim_in;
      offset_ff  <= offset_in;
      empty_ff   <= empty_in;
      merged_ff  <= merged_in;
      noloops_ff <= noloops_in;
      done_ff    <= done_in;
      last_ff    <= last_in;
      prod_ff    <= prod_in;
      rdest_ff   <= rdest_in;
      rsrc_ff    <= rsrc_in;
      rcount_ff  <= rcount_in;
      rskip_ff   <= rskip_in;
      rlast_ff   <= rlast_in;
      rdone_ff   <= rdone_in;
   end

   assign status.scan_end = at_end;
   assign status.adv_end  = done_ff || noloops_ff || !wrap || (dim_ff == '0);
   assign status.out_free = !rvalid_ff || !rsp_stall;

   assign rsp_valid          = rvalid_ff;
   assign rsp_dest_address   = rdest_ff;
   assign rsp_source_address = rsrc_ff;
   assign rsp_byte_count     = rcount_ff;
   assign rsp_skip           = rskip_ff;
   assign rsp_last           = rlast_ff;
   assign rsp_done_res       = rdone_ff;

endmodule

// ===== hdl/strided_nd_copy_address_generator_core.sv =====
// Top level: register port, controller and datapath of the strided copy address generator.
// Load and restart words are accepted, then the table or counters are updated.
// A step word holds the input through acceptance, the offset scan over the dimensions in use
// (one per cycle), the carry through the counters it visits (at least one), and an emit step;
// the emit waits while the output is held, and its result is then valid in the output register.
// One word is in progress at a time; a finished result waits in the output register.
// Synchronous reset clears descriptor tables, counters and offsets, and loads register defaults.
module strided_nd_copy_address_generator_core #(
   parameter int MAX_DIMS  = sndc_pkg::MAX_DIMS_DEF,
   parameter int ADDR_BITS = sndc_pkg::ADDR_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_operation,
   input  logic [2:0]                        req_dim_index,
   input  logic [sndc_pkg::LEN_W-1:0]        req_dim_length,
   input  logic [sndc_pkg::STR_W-1:0]        req_dim_stride,
   input  logic [sndc_pkg::DIST_W-1:0]       req_dim_distance,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sndc_pkg::OUT_ADDR_W-1:0]   rsp_dest_address,
   output logic [sndc_pkg::OUT_ADDR_W-1:0]   rsp_source_address,
   output logic [sndc_pkg::COUNT_W-1:0]      rsp_byte_count,
   output logic                              rsp_skip,
   output logic                              rsp_last,
   output logic                              rsp_done_res,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sndc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sndc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sndc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import sndc_pkg::*;

   logic [1:0]            mode_ff, mode_in;
   logic [EB_W-1:0]       eb_ff, eb_in;
   logic [2:0]            ndim_ff, ndim_in;
   logic [OUT_ADDR_W-1:0] dbase_ff, dbase_in;
   logic [OUT_ADDR_W-1:0] sbase_ff, sbase_in;
   logic [2:0]            csr_idx;
   logic                  csr_wr;

   cmd_type    cmd;
   status_type status;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[5:3];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      mode_in  = mode_ff;
      eb_in    = eb_ff;
      ndim_in  = ndim_ff;
      dbase_in = dbase_ff;
      sbase_in = sbase_ff;
      if (csr_wr) begin
         case (csr_idx)
            CSR_COPY_MODE:     mode_in  = csr_pwdata[1:0];
            CSR_ELEMENT_BYTES: eb_in    = csr_pwdata[EB_W-1:0];
            CSR_DIM_COUNT:     ndim_in  = csr_pwdata[2:0];
            CSR_DEST_BASE:     dbase_in = csr_pwdata[OUT_ADDR_W-1:0];
            CSR_SRC_BASE:      sbase_in = csr_pwdata[OUT_ADDR_W-1:0];
            default:           ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_COPY_MODE:     csr_prdata = CSR_DATA_W'(mode_ff);
         CSR_ELEMENT_BYTES: csr_prdata = CSR_DATA_W'(eb_ff);
         CSR_DIM_COUNT:     csr_prdata = CSR_DATA_W'(ndim_ff);
         CSR_DEST_BASE:     csr_prdata = CSR_DATA_W'(dbase_ff);
         CSR_SRC_BASE:      csr_prdata = CSR_DATA_W'(sbase_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_PACK;
         eb_ff    <= EB_W'(1);
         ndim_ff  <= 3'd1;
         dbase_ff <= '0;
         sbase_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         eb_ff    <= eb_in;
         ndim_ff  <= ndim_in;
         dbase_ff <= dbase_in;
         sbase_ff <= sbase_in;
      end
   end

   sndc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   sndc_dp #(
      .MAX_DIMS  (MAX_DIMS),
      .ADDR_BITS (ADDR_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_dim_index      (req_dim_index),
      .req_dim_length     (req_dim_length),
      .req_dim_stride     (req_dim_stride),
      .req_dim_distance   (req_dim_distance),
      .copy_mode          (mode_ff),
      .element_bytes      (eb_ff),
      .dim_count          (ndim_ff),
      .dest_base          (dbase_ff),
      .src_base           (sbase_ff),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_dest_address   (rsp_dest_address),
      .rsp_source_address (rsp_source_address),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_skip           (rsp_skip),
      .rsp_last           (rsp_last),
      .rsp_done_res       (rsp_done_res)
   );

   a_done_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> (rsp_dest_address == '0 && rsp_source_address == '0
         && rsp_byte_count == '0 && !rsp_skip && !rsp_last))
      else $error("done word carries nonzero fields");

   a_skip_scalar_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_skip) |-> mode_ff[MODE_SCALAR_BIT])
      else $error("skip set outside scalar broadcast");

   a_no_result_after_load: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_operation != OP_STEP) |=> !$rose(rsp_valid))
      else $error("result produced by a non-step word");

   a_stall_while_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_operation == OP_STEP) |=> req_stall)
      else $error("new word accepted while a step is in progress");

endmodule

// ===== tb/sndc_copy_checker.sv =====
`timescale 1ns / 1ps
// Checker: watches request, result and register traffic, predicts each copy word and compares.
module sndc_copy_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [1:0]                      req_operation,
   input  logic [2:0]                      req_dim_index,
   input  logic [sndc_pkg::LEN_W-1:0]      req_dim_length,
   input  logic [sndc_pkg::STR_W-1:0]      req_dim_stride,
   input  logic [sndc_pkg::DIST_W-1:0]     req_dim_distance,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [sndc_pkg::OUT_ADDR_W-1:0] rsp_dest_address,
   input  logic [sndc_pkg::OUT_ADDR_W-1:0] rsp_source_address,
   input  logic [sndc_pkg::COUNT_W-1:0]    rsp_byte_count,
   input  logic                            rsp_skip,
   input  logic                            rsp_last,
   input  logic                            rsp_done_res,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic                            csr_pready,
   input  logic [sndc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sndc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output int                              mismatches,
   output int                              pending,
   output int                              copies_checked,
   output int                              done_seen,
   output int                              skips_seen
);
   import sndc_pkg::*;

   localparam int NDIM = MAX_DIMS_DEF;

   typedef struct packed {
      logic [OUT_ADDR_W-1:0] dest;
      logic [OUT_ADDR_W-1:0] src;
      logic [COUNT_W-1:0]    count;
      logic                  skip;
      logic                  last;
      logic                  done;
   } copy_word_type;

   copy_word_type copy_q[$];

   logic [1:0]            mode_r;
   logic [EB_W-1:0]       ebytes_r;
   logic [2:0]            ndim_r;
   logic [OUT_ADDR_W-1:0] dbase_r;
   logic [OUT_ADDR_W-1:0] sbase_r;

   logic [LEN_W-1:0]      len_tab [NDIM];
   logic [BSTR_W-1:0]     bstr_tab[NDIM];
   logic                  unit_tab[NDIM];
   logic [LEN_W-1:0]      idx_cnt [NDIM];
   logic [OUT_ADDR_W-1:0] off_tab [NDIM];
   logic [OUT_ADDR_W-1:0] pack_off;
   logic                  xfer_done;

   initial begin
      mismatches     = 0;
      pending        = 0;
      copies_checked = 0;
      done_seen      = 0;
      skips_seen     = 0;
   end

   task automatic clear_progress();
      for (int d = 0; d < NDIM; d++) begin
         idx_cnt[d] = '0;
         off_tab[d] = '0;
      end
      pack_off  = '0;
      xfer_done = 1'b0;
   endtask

   task automatic note_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_COPY_MODE:     mode_r   = val[1:0];
         CSR_ELEMENT_BYTES: ebytes_r = val[EB_W-1:0];
         CSR_DIM_COUNT:     ndim_r   = val[2:0];
         CSR_DEST_BASE:     dbase_r  = val[OUT_ADDR_W-1:0];
         CSR_SRC_BASE:      sbase_r  = val[OUT_ADDR_W-1:0];
         default: ;
      endcase
   endtask

   // next copy of the transfer, advancing the index counters
   task automatic predict_step();
      int                    n;
      int                    loops;
      logic                  scalar;
      logic                  merged;
      logic                  empty;
      logic                  is_last;
      logic [OUT_ADDR_W-1:0] offs;
      logic [OUT_ADDR_W-1:0] dst;
      logic [OUT_ADDR_W-1:0] src;
      logic [PROD_W-1:0]     prod;
      logic [COUNT_W-1:0]    chunk;
      copy_word_type         c;
      n = int'(ndim_r);
      if (n == 0) n = 1;
      if (n > NDIM) n = NDIM;
      scalar = mode_r[MODE_SCALAR_BIT];
      merged = !scalar && unit_tab[n-1];
      loops  = merged ? n - 1 : n;
      empty  = 1'b0;
      for (int d = 0; d < n; d++)
         if (len_tab[d] == '0) empty = 1'b1;
      c = '0;
      if (xfer_done || empty) begin
         c.done = 1'b1;
      end else begin
         offs = '0;
         for (int d = 0; d < loops; d++)
            offs = offs + off_tab[d];
         if (merged) begin
            prod  = ebytes_r * len_tab[n-1];
            chunk = (prod > {1'b0, COUNT_MAX}) ? COUNT_MAX : prod[COUNT_W-1:0];
         end else begin
            chunk = COUNT_W'(ebytes_r);
         end
         if (scalar) begin
            dst = dbase_r + offs;
            src = sbase_r;
         end else if (!mode_r[MODE_UNPACK_BIT]) begin
            dst = dbase_r + pack_off;
            src = sbase_r + offs;
         end else begin
            dst = dbase_r + offs;
            src = sbase_r + pack_off;
         end
         if (!scalar) pack_off = pack_off + OUT_ADDR_W'(chunk);
         is_last = 1'b1;
         for (int d = loops - 1; d >= 0; d--) begin
            if ({1'b0, idx_cnt[d]} + 17'd1 >= {1'b0, len_tab[d]}) begin
               idx_cnt[d] = '0;
               off_tab[d] = '0;
            end else begin
               idx_cnt[d] = idx_cnt[d] + 1'b1;
               off_tab[d] = off_tab[d] + OUT_ADDR_W'(bstr_tab[d]);
               is_last    = 1'b0;
               break;
            end
         end
         if (is_last) xfer_done = 1'b1;
         c.dest  = dst;
         c.src   = src;
         c.count = chunk;
         c.skip  = scalar && (dst == src);
         c.last  = is_last;
      end
      copy_q.push_back(c);
   endtask

   task automatic apply_word();
      int di;
      di = int'(req_dim_index);
      case (req_operation)
         OP_LOAD: begin
            if (di < NDIM) begin
               len_tab[di]  = req_dim_length;
               bstr_tab[di] = req_dim_stride * req_dim_distance;
               unit_tab[di] = (req_dim_stride == STR_W'(1));
            end
         end
         OP_RESTART: clear_progress();
         OP_STEP:    predict_step();
         default: ;
      endcase
   endtask

   task automatic check_copy();
      copy_word_type got;
      copy_word_type want;
      got = {rsp_dest_address, rsp_source_address, rsp_byte_count,
             rsp_skip, rsp_last, rsp_done_res};
      if (copy_q.size() == 0) begin
         note_mismatch("word with nothing expected", got.dest, '0);
         return;
      end
      want = copy_q.pop_front();
      if (got.dest !== want.dest)   note_mismatch("dest_address", got.dest, want.dest);
      if (got.src !== want.src)     note_mismatch("source_address", got.src, want.src);
      if (got.count !== want.count) note_mismatch("byte_count", got.count, want.count);
      if (got.skip !== want.skip)   note_mismatch("skip", got.skip, want.skip);
      if (got.last !== want.last)   note_mismatch("last", got.last, want.last);
      if (got.done !== want.done)   note_mismatch("done_res", got.done, want.done);
      copies_checked++;
      if (want.done) done_seen++;
      if (want.skip) skips_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode_r   = MODE_PACK;
         ebytes_r = EB_W'(1);
         ndim_r   = 3'd1;
         dbase_r  = '0;
         sbase_r  = '0;
         for (int d = 0; d < NDIM; d++) begin
            len_tab[d]  = '0;
            bstr_tab[d] = '0;
            unit_tab[d] = 1'b0;
         end
         clear_progress();
         copy_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_copy();
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            write_reg(csr_paddr[5:3], csr_pwdata);
         if (req_valid && !req_stall) apply_word();
      end
      pending = copy_q.size();
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, descriptor and step stimulus, back-pressure, watchdog, verdict.
module tb;
   import sndc_pkg::*;

   localparam int HOLD_CYCLES     = 300;
   localparam int IDLE_GAP        = 30;
   localparam int STUCK_LIMIT     = 4000;
   localparam int WORDS_PER_PHASE = 430;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_operation    = '0;
   logic [2:0]            req_dim_index    = '0;
   logic [LEN_W-1:0]      req_dim_length   = '0;
   logic [STR_W-1:0]      req_dim_stride   = '0;
   logic [DIST_W-1:0]     req_dim_distance = '0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic [OUT_ADDR_W-1:0] rsp_dest_address;
   logic [OUT_ADDR_W-1:0] rsp_source_address;
   logic [COUNT_W-1:0]    rsp_byte_count;
   logic                  rsp_skip;
   logic                  rsp_last;
   logic                  rsp_done_res;
   logic                  csr_psel         = 1'b0;
   logic                  csr_penable      = 1'b0;
   logic                  csr_pwrite       = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr        = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata       = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int mismatches;
   int pending;
   int copies_checked;
   int done_seen;
   int skips_seen;

   int snd_pct    = 0;
   int rcv_pct    = 0;
   int hold_token = 0;
   int hold_seen  = 0;
   int hold_left  = 0;
   int word_count = 0;
   int reg_sets   = 0;
   int stuck      = 0;
   bit squeeze_next;

   strided_nd_copy_address_generator_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_dim_index      (req_dim_index),
      .req_dim_length     (req_dim_length),
      .req_dim_stride     (req_dim_stride),
      .req_dim_distance   (req_dim_distance),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_dest_address   (rsp_dest_address),
      .rsp_source_address (rsp_source_address),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_skip           (rsp_skip),
      .rsp_last           (rsp_last),
      .rsp_done_res       (rsp_done_res),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   sndc_copy_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_dim_index      (req_dim_index),
      .req_dim_length     (req_dim_length),
      .req_dim_stride     (req_dim_stride),
      .req_dim_distance   (req_dim_distance),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_dest_address   (rsp_dest_address),
      .rsp_source_address (rsp_source_address),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_skip           (rsp_skip),
      .rsp_last           (rsp_last),
      .rsp_done_res       (rsp_done_res),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_pready         (csr_pready),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .mismatches         (mismatches),
      .pending            (pending),
      .copies_checked     (copies_checked),
      .done_seen          (done_seen),
      .skips_seen         (skips_seen)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // result side: random stall, or a long hold-off when requested
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_pct);
      end
   end

   initial begin
      while (stuck < STUCK_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
            stuck = 0;
         else
            stuck++;
      end
      $display("watchdog: no progress for %0d cycles", STUCK_LIMIT);
      $display("tb: failure");
      $finish;
   end

   task automatic put_word(input logic [1:0] op, input logic [2:0] idx,
                           input logic [LEN_W-1:0] len, input logic [STR_W-1:0] str,
                           input logic [DIST_W-1:0] distance);
      while ($urandom_range(99) < snd_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_dim_index    <= idx;
      req_dim_length   <= len;
      req_dim_stride   <= str;
      req_dim_distance <= distance;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      if (!(op == OP_UNUSED || (op == OP_LOAD && idx >= 3'(MAX_DIMS_DEF))))
         word_count++;
   endtask

   // restart or step, unused fields random
   task automatic put_ctrl(input logic [1:0] op);
      put_word(op, 3'($urandom), LEN_W'($urandom), STR_W'($urandom), DIST_W'($urandom));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (IDLE_GAP) @(posedge clock);
   endtask

   task automatic reg_write(input logic [2:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (!csr_pready);
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [1:0] mode, input logic [EB_W-1:0] eb,
                               input logic [2:0] nd, input logic [OUT_ADDR_W-1:0] db,
                               input logic [OUT_ADDR_W-1:0] sb);
      logic [63:0] junk;
      wait_idle();
      junk = {$urandom, $urandom};
      reg_write(CSR_COPY_MODE,     {junk[63:2], mode});
      reg_write(CSR_ELEMENT_BYTES, {junk[63:EB_W], eb});
      reg_write(CSR_DIM_COUNT,     {junk[63:3], nd});
      reg_write(CSR_DEST_BASE,     {junk[63:48], db});
      reg_write(CSR_SRC_BASE,      {junk[47:32], sb});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      reg_sets++;
   endtask

   function automatic logic [LEN_W-1:0] pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 45) return LEN_W'(1);
      if (r < 70) return LEN_W'($urandom_range(2, 3));
      if (r < 78) return '0;
      if (r < 88) return LEN_W'($urandom_range(4, 9));
      return LEN_W'($urandom);
   endfunction

   function automatic logic [STR_W-1:0] pick_stride();
      int r;
      r = $urandom_range(99);
      if (r < 40) return STR_W'(1);
      if (r < 70) return STR_W'($urandom_range(0, 4));
      return STR_W'($urandom);
   endfunction

   function automatic logic [DIST_W-1:0] pick_distance();
      int r;
      r = $urandom_range(99);
      if (r < 50) return DIST_W'($urandom_range(0, 64));
      return DIST_W'($urandom);
   endfunction

   function automatic logic [OUT_ADDR_W-1:0] pick_base();
      int r;
      r = $urandom_range(99);
      if (r < 15) return '0;
      if (r < 30) return '1;
      return OUT_ADDR_W'({$urandom, $urandom});
   endfunction

   task automatic directed_words();
      // nothing loaded yet: every dimension empty
      put_ctrl(OP_STEP);
      put_word(OP_UNUSED, 3'd7, '1, '1, '1);
      put_word(OP_LOAD, 3'd7, LEN_W'(5), STR_W'(1), DIST_W'(1));
      put_ctrl(OP_STEP);
      // one merged dimension whose chunk saturates
      program_regs(MODE_PACK, '1, 3'd1, '0, '0);
      put_word(OP_LOAD, 3'd0, '1, STR_W'(1), '1);
      put_ctrl(OP_RESTART);
      put_ctrl(OP_STEP);
      put_ctrl(OP_STEP);
      // unpack, zero element size, addresses wrapping
      program_regs(MODE_UNPACK, '0, 3'd2, '1, '1);
      put_word(OP_LOAD, 3'd0, LEN_W'(2), '1, '1);
      put_word(OP_LOAD, 3'd1, LEN_W'(3), STR_W'(2), DIST_W'(1));
      put_ctrl(OP_RESTART);
      repeat (7) put_ctrl(OP_STEP);
      // scalar broadcast onto itself, dimension count zero
      program_regs(MODE_SCALAR, EB_W'(3), 3'd0, OUT_ADDR_W'(48'h1000), OUT_ADDR_W'(48'h1000));
      put_word(OP_LOAD, 3'd0, LEN_W'(2), '0, DIST_W'(5));
      put_ctrl(OP_RESTART);
      repeat (3) put_ctrl(OP_STEP);
      // undefined mode, all dimensions, unloaded ones empty
      program_regs(MODE_UNDEFINED, EB_W'(4096), 3'd7, '0, OUT_ADDR_W'(48'h7FFF_FFFF_FFFF));
      put_ctrl(OP_STEP);
   endtask

   task automatic run_transfer(input bit squeeze);
      logic [1:0]            mode;
      logic [EB_W-1:0]       eb;
      logic [2:0]            nd;
      logic [OUT_ADDR_W-1:0] db;
      logic [OUT_ADDR_W-1:0] sb;
      int                    steps;
      if (squeeze || $urandom_range(4) != 0) begin
         mode = 2'($urandom_range(3));
         case ($urandom_range(7))
            0:       eb = '0;
            1:       eb = '1;
            2:       eb = EB_W'(4096);
            3:       eb = EB_W'(1);
            default: eb = EB_W'($urandom_range(2, 64));
         endcase
         nd = 3'($urandom_range(7));
         db = pick_base();
         sb = ($urandom_range(3) == 0) ? db : pick_base();
         program_regs(mode, eb, nd, db, sb);
      end
      for (int d = 0; d < MAX_DIMS_DEF; d++)
         if ($urandom_range(9) < 8)
            put_word(OP_LOAD, 3'(d), pick_length(), pick_stride(), pick_distance());
      if (squeeze || $urandom_range(9) != 0) put_ctrl(OP_RESTART);
      // long result hold-off while steps keep coming
      if (squeeze) hold_token <= hold_token + 1;
      steps = squeeze ? 40 : $urandom_range(3, 24);
      for (int s = 0; s < steps; s++) begin
         if (!squeeze && $urandom_range(19) == 0)
            put_word(2'($urandom), 3'($urandom), LEN_W'($urandom), STR_W'($urandom),
                     DIST_W'($urandom));
         else
            put_ctrl(OP_STEP);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_words();
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               snd_pct = 29;
               rcv_pct <= 64;
            end
            1: begin
               snd_pct = 64;
               rcv_pct <= 29;
            end
            default: begin
               snd_pct = 0;
               rcv_pct <= 0;
            end
         endcase
         squeeze_next = (phase == 2);
         while (word_count < WORDS_PER_PHASE * (phase + 1) + 24) begin
            run_transfer(squeeze_next);
            squeeze_next = 1'b0;
         end
      end
      wait_idle();
      $display("summary: %0d words in 3 idle patterns, %0d register settings over all modes",
               word_count, reg_sets);
      $display("summary: %0d copies checked, %0d end answers, %0d skips, %0d mismatches",
               copies_checked, done_seen, skips_seen, mismatches);
      if (mismatches == 0 && pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/sndc_pkg.sv
hdl/sndc_ctrl.sv
hdl/sndc_dp.sv
hdl/strided_nd_copy_address_generator_core.sv
tb/sndc_copy_checker.sv
tb/tb.sv
